[rtl/assert_macros.svh]
// Assertion macros for the frame decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while in reset.
`define HTFD_AST_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame decoder check failed");

// Delayed implication, sampled on clk and switched off while in reset.
`define HTFD_AST_LAG2(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("frame decoder check failed");

`endif

[rtl/htfd_pkg.sv]
// Shared constants and types of the humidity/temperature frame decoder.
package htfd_pkg;

    localparam int MAX_CHANGES = 85;
    localparam int FRAME_BITS  = 40;

    localparam int THR_W      = 8;
    localparam int DUR_W      = 10;
    localparam int CC_W       = 7;
    localparam int BC_W       = 6;
    localparam int HUM_W      = 10;
    localparam int TEMP_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAHRENHEIT    = 2'd2;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_CHANGE = 1'b1;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd48;
    localparam logic [DUR_W-1:0] TIMEOUT_RST   = 10'd250;

    localparam logic [BC_W-1:0] BIT_COUNT_MAX = 6'd63;
    localparam logic [15:0]     HUM_LIMIT     = 16'd1000;

    // Fahrenheit: floor((18*C + 3205) / 10) computed with a positive bias of
    // one million added to the dividend and 100000 taken off the quotient.
    localparam int                 X_W          = 21;
    localparam logic signed [21:0] X_BIAS       = 22'sd1003205;
    localparam int                 RECIP_SHIFT  = 28;
    localparam int                 RECIP_W      = 25;
    localparam logic [RECIP_W-1:0] RECIP_TEN    = 25'd26843546;
    localparam int                 Q_W          = 18;
    localparam logic signed [18:0] Q_UNBIAS     = 19'sd100000;

    typedef struct packed {
        logic [THR_W-1:0] bit_threshold_us;
        logic [DUR_W-1:0] timeout_us;
        logic             fahrenheit_mode;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] bits;
        logic                  enough;
        logic                  fahr;
    } snap_t;

    typedef struct packed {
        logic            active;
        logic [CC_W-1:0] change_count;
    } frame_status_t;

endpackage

[rtl/htfd_channels.sv]
// Valid/ready channel interfaces for line events and decoded readings.
interface htfd_event_if;
    import htfd_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [DUR_W-1:0] duration_us;

    modport source (output valid, output func, output duration_us, input ready);
    modport sink   (input valid, input func, input duration_us, output ready);
endinterface

interface htfd_reading_if;
    import htfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     valid_res;
    logic [HUM_W-1:0]         humidity_tenths;
    logic signed [TEMP_W-1:0] temperature_tenths;

    modport source (output valid, output valid_res, output humidity_tenths,
                    output temperature_tenths, input ready);
    modport sink   (input valid, input valid_res, input humidity_tenths,
                    input temperature_tenths, output ready);
endinterface

[rtl/htfd_frame.sv]
// Event input register and per-frame bit collection state.
module htfd_frame (
    input  logic                    clk,
    input  logic                    rst_n,
    htfd_event_if.sink              events,
    input  htfd_pkg::cfg_t          cfg,
    input  logic                    snap_free,
    output logic                    snap_vld,
    output htfd_pkg::snap_t         snap,
    output htfd_pkg::frame_status_t status
);
    import htfd_pkg::*;

    logic                  ev_vld_reg;
    logic                  func_reg;
    logic [DUR_W-1:0]      dur_reg;
    logic                  active_reg;
    logic [CC_W-1:0]       cc_reg;
    logic [BC_W-1:0]       bc_reg;
    logic [FRAME_BITS-1:0] bits_reg;

    logic                  take_bit;
    logic                  one_bit;
    logic [FRAME_BITS-1:0] bits_next;
    logic [BC_W-1:0]       bc_next;
    logic [CC_W-1:0]       cc_next;
    logic                  is_change;
    logic                  closes;
    logic                  go;

    always_comb
    begin
        // Changes four, six, eight and so on are the high halves of data bits.
        take_bit  = (cc_reg > 7'd2) && !cc_reg[0];
        one_bit   = dur_reg > {2'b00, cfg.bit_threshold_us};
        bits_next = bits_reg;
        if (take_bit && (bc_reg < BC_W'(FRAME_BITS)))
        begin
            bits_next = {bits_reg[FRAME_BITS-2:0], one_bit};
        end
        bc_next = bc_reg;
        if (take_bit && (bc_reg != BIT_COUNT_MAX))
        begin
            bc_next = bc_reg + 1'b1;
        end
        cc_next   = cc_reg + 1'b1;
        is_change = ev_vld_reg && (func_reg == FUNC_CHANGE) && active_reg;
        closes    = is_change
                    && ((cc_next >= CC_W'(MAX_CHANGES)) || (dur_reg >= cfg.timeout_us));
        go        = ev_vld_reg && (!closes || snap_free);
    end

    assign events.ready = !ev_vld_reg || go;

    assign snap_vld    = closes;
    assign snap.bits   = bits_next;
    assign snap.enough = bc_next >= BC_W'(FRAME_BITS);
    assign snap.fahr   = cfg.fahrenheit_mode;

    assign status.active       = active_reg;
    assign status.change_count = cc_reg;

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            func_reg <= events.func;
            dur_reg  <= events.duration_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_vld_reg <= 1'b0;
            active_reg <= 1'b0;
            cc_reg     <= '0;
            bc_reg     <= '0;
            bits_reg   <= '0;
        end
        else
        begin
            if (events.ready)
            begin
                ev_vld_reg <= events.valid;
            end
            if (go)
            begin
                if (func_reg == FUNC_START)
                begin
                    active_reg <= 1'b1;
                    cc_reg     <= '0;
                    bc_reg     <= '0;
                    bits_reg   <= '0;
                end
                else if (active_reg)
                begin
                    cc_reg   <= cc_next;
                    bc_reg   <= bc_next;
                    bits_reg <= bits_next;
                    if (closes)
                    begin
                        active_reg <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

[rtl/htfd_result.sv]
// Result pipeline: frame checks, Fahrenheit conversion and output register.
module htfd_result (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            snap_vld,
    input  htfd_pkg::snap_t snap,
    output logic            snap_free,
    htfd_reading_if.source  reading
);
    import htfd_pkg::*;

    // Snapshot stage
    logic  b_vld_reg;
    snap_t b_snap_reg;

    // Check stage
    logic                     c_vld_reg;
    logic                     c_ok_reg;
    logic                     c_fahr_reg;
    logic [HUM_W-1:0]         c_hum_reg;
    logic signed [TEMP_W-1:0] c_cel_reg;
    logic [X_W-1:0]           c_x_reg;

    // Division stage
    logic                     d_vld_reg;
    logic                     d_ok_reg;
    logic                     d_fahr_reg;
    logic [HUM_W-1:0]         d_hum_reg;
    logic signed [TEMP_W-1:0] d_cel_reg;
    logic [Q_W-1:0]           d_q_reg;

    // Output stage
    logic                     o_vld_reg;
    logic                     o_ok_reg;
    logic [HUM_W-1:0]         o_hum_reg;
    logic signed [TEMP_W-1:0] o_temp_reg;

    logic b_free, c_free, d_free, o_free;

    logic [7:0]               byte0, byte1, byte2, byte3, byte4;
    logic [7:0]               csum;
    logic [15:0]              hum;
    logic                     ok;
    logic [14:0]              tmag;
    logic signed [TEMP_W-1:0] cel;
    logic signed [21:0]       cel_w;
    logic signed [21:0]       x_s;

    logic [X_W+RECIP_W-1:0]   prod;

    logic signed [18:0]       fahr_w;
    logic signed [TEMP_W-1:0] temp_sel;

    // A stage takes new data when it is empty or its contents move on.
    assign o_free    = !o_vld_reg || reading.ready;
    assign d_free    = !d_vld_reg || o_free;
    assign c_free    = !c_vld_reg || d_free;
    assign b_free    = !b_vld_reg || c_free;
    assign snap_free = b_free;

    always_comb
    begin
        byte0 = b_snap_reg.bits[39:32];
        byte1 = b_snap_reg.bits[31:24];
        byte2 = b_snap_reg.bits[23:16];
        byte3 = b_snap_reg.bits[15:8];
        byte4 = b_snap_reg.bits[7:0];
        csum  = byte0 + byte1 + byte2 + byte3;
        hum   = {byte0, byte1};
        ok    = b_snap_reg.enough && (byte4 == csum) && (hum <= HUM_LIMIT);
        tmag  = {byte2[6:0], byte3};
        cel   = byte2[7] ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag});
        cel_w = {{5{cel[TEMP_W-1]}}, cel};
        x_s   = (cel_w <<< 4) + (cel_w <<< 1) + X_BIAS;
    end

    assign prod = c_x_reg * RECIP_TEN;

    always_comb
    begin
        fahr_w   = $signed({1'b0, d_q_reg}) - Q_UNBIAS;
        temp_sel = d_fahr_reg ? fahr_w[TEMP_W-1:0] : d_cel_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_free && snap_vld)
        begin
            b_snap_reg <= snap;
        end
        if (c_free && b_vld_reg)
        begin
            c_ok_reg   <= ok;
            c_fahr_reg <= b_snap_reg.fahr;
            c_hum_reg  <= hum[HUM_W-1:0];
            c_cel_reg  <= cel;
            c_x_reg    <= x_s[X_W-1:0];
        end
        if (d_free && c_vld_reg)
        begin
            d_ok_reg   <= c_ok_reg;
            d_fahr_reg <= c_fahr_reg;
            d_hum_reg  <= c_hum_reg;
            d_cel_reg  <= c_cel_reg;
            d_q_reg    <= prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        end
        if (o_free && d_vld_reg)
        begin
            o_ok_reg   <= d_ok_reg;
            o_hum_reg  <= d_ok_reg ? d_hum_reg : '0;
            o_temp_reg <= d_ok_reg ? temp_sel : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
            begin
                b_vld_reg <= snap_vld;
            end
            if (c_free)
            begin
                c_vld_reg <= b_vld_reg;
            end
            if (d_free)
            begin
                d_vld_reg <= c_vld_reg;
            end
            if (o_free)
            begin
                o_vld_reg <= d_vld_reg;
            end
        end
    end

    assign reading.valid              = o_vld_reg;
    assign reading.valid_res          = o_ok_reg;
    assign reading.humidity_tenths    = o_hum_reg;
    assign reading.temperature_tenths = o_temp_reg;

endmodule

[rtl/humidity_temp_frame_decoder_top.sv]
// Top level of the single-wire humidity/temperature frame decoder.
//
// The events channel takes one beat per line event: func = 0 opens a new
// frame, func = 1 reports a level change with the time the line held its
// previous level. The frame closes after 85 changes or on a change whose
// duration reaches the timeout; the reading channel then carries one beat
// with the check flag, humidity and temperature in tenths.
// One event beat is accepted every cycle unless the input stalls. After the
// closing event beat is accepted, the reading passes through the input
// register, snapshot, checks, reciprocal multiply for the Fahrenheit
// division and output register.
// When the reading sink stalls, the pipeline stages behind the output fill
// up; events that close no frame keep flowing, and the input stalls only
// when a closing event finds no free stage behind it.
// Reset clears the pipeline and the frame state, leaves no frame open and
// loads the register defaults. The user must write registers via cfg_we,
// cfg_index and cfg_data while no frame is in flight; nothing enforces it.
`include "assert_macros.svh"

module humidity_temp_frame_decoder_top (
    input  logic                             clk,
    input  logic                             rst_n,
    htfd_event_if.sink                       events,
    htfd_reading_if.source                   reading,
    input  logic                             cfg_we,
    input  logic [htfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [htfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import htfd_pkg::*;

    cfg_t          cfg_reg;
    logic          snap_vld;
    snap_t         snap;
    logic          snap_free;
    frame_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_threshold_us <= THRESHOLD_RST;
            cfg_reg.timeout_us       <= TIMEOUT_RST;
            cfg_reg.fahrenheit_mode  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIT_THRESHOLD: cfg_reg.bit_threshold_us <= cfg_data[THR_W-1:0];
                REG_TIMEOUT:       cfg_reg.timeout_us       <= cfg_data[DUR_W-1:0];
                REG_FAHRENHEIT:    cfg_reg.fahrenheit_mode  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    htfd_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events),
        .cfg       (cfg_reg),
        .snap_free (snap_free),
        .snap_vld  (snap_vld),
        .snap      (snap),
        .status    (status)
    );

    htfd_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap_vld  (snap_vld),
        .snap      (snap),
        .snap_free (snap_free),
        .reading   (reading)
    );

    // A failed reading reports zero values.
    `HTFD_AST_IMP(a_zero_on_fail, reading.valid && !reading.valid_res, reading.humidity_tenths == '0 && reading.temperature_tenths == '0)
    // A passed reading never carries humidity above the limit.
    `HTFD_AST_IMP(a_hum_range, reading.valid && reading.valid_res, reading.humidity_tenths <= HUM_LIMIT[HUM_W-1:0])
    // An open frame has always closed before its change count reaches the limit.
    `HTFD_AST_IMP(a_count_bound, status.active, status.change_count < CC_W'(MAX_CHANGES))
    // A start beat opens a clean frame once it leaves the input register.
    `HTFD_AST_LAG2(a_start_opens, events.valid && events.ready && events.func == FUNC_START, status.active && status.change_count == '0)

endmodule

[verif/tb_humidity_temp_frame_decoder_top.sv]
// Self-checking testbench for the single-wire humidity/temperature frame decoder.
module tb_humidity_temp_frame_decoder_top;
    import htfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PCT      = 14;
    localparam int FIRST_BIT_CHG = 4;

    typedef struct packed {
        logic                     valid_res;
        logic [HUM_W-1:0]         humidity_tenths;
        logic signed [TEMP_W-1:0] temperature_tenths;
    } reading_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    htfd_event_if   events ();
    htfd_reading_if reading ();

    humidity_temp_frame_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events),
        .reading   (reading),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the decoder: registers and frame state.
    logic [THR_W-1:0]      thr_us;
    logic [DUR_W-1:0]      tmo_us;
    logic                  in_fahrenheit;
    logic [CC_W-1:0]       changes_seen;
    logic [BC_W-1:0]       bits_seen;
    logic [FRAME_BITS-1:0] frame_word;
    logic                  frame_open;

    reading_t expected_readings[$];
    int       error_count   = 0;
    int       readings_due  = 0;
    int       live_beats    = 0;
    int       stall_request = 0;
    bit       calm          = 1'b0;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_decoder_copy();
        thr_us        = THRESHOLD_RST;
        tmo_us        = TIMEOUT_RST;
        in_fahrenheit = 1'b0;
        changes_seen  = '0;
        bits_seen     = '0;
        frame_word    = '0;
        frame_open    = 1'b0;
    endfunction

    function automatic reading_t decode_reading();
        reading_t   r;
        logic [7:0] b0, b1, b2, b3, b4;
        logic [7:0] sum8;
        logic [15:0] hum;
        int         t;
        {b0, b1, b2, b3, b4} = frame_word;
        sum8 = b0 + b1 + b2 + b3;
        hum  = {b0, b1};
        r    = '0;
        if (bits_seen >= FRAME_BITS && b4 == sum8 && hum <= HUM_LIMIT)
        begin
            t = int'({b2[6:0], b3});
            if (b2[7])
                t = -t;
            // Nearest tenth of 1.8 C + 32; the bias keeps the division on positive values.
            if (in_fahrenheit)
                t = (2 * (t * 9 + 1600) + 5 + 1000000) / 10 - 100000;
            r.valid_res          = 1'b1;
            r.humidity_tenths    = hum[HUM_W-1:0];
            r.temperature_tenths = t[TEMP_W-1:0];
        end
        return r;
    endfunction

    function automatic void track_event(input logic func, input logic [DUR_W-1:0] dur);
        if (func == FUNC_START)
        begin
            changes_seen = '0;
            bits_seen    = '0;
            frame_word   = '0;
            frame_open   = 1'b1;
            live_beats++;
            return;
        end
        if (!frame_open)
            return;
        live_beats++;
        // Even changes from the fourth onwards are the high pulses that carry data.
        if (changes_seen > 2 && !changes_seen[0])
        begin
            if (bits_seen < FRAME_BITS)
                frame_word = {frame_word[FRAME_BITS-2:0], dur > thr_us};
            if (bits_seen != BIT_COUNT_MAX)
                bits_seen++;
        end
        changes_seen++;
        if (changes_seen >= MAX_CHANGES || dur >= tmo_us)
        begin
            expected_readings.push_back(decode_reading());
            readings_due++;
            frame_open = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BIT_THRESHOLD: thr_us        = data[THR_W-1:0];
            REG_TIMEOUT:       tmo_us        = data;
            REG_FAHRENHEIT:    in_fahrenheit = data[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int thr, input int tmo, input bit fahr);
        write_reg(REG_BIT_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
        write_reg(REG_FAHRENHEIT, CFG_DATA_W'(fahr));
    endtask

    task automatic send_event(input logic func, input logic [DUR_W-1:0] dur);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            events.valid <= 1'b0;
        end
        @(negedge clk);
        events.valid       <= 1'b1;
        events.func        <= func;
        events.duration_us <= dur;
        @(posedge clk);
        while (!events.ready)
            @(posedge clk);
        track_event(func, dur);
    endtask

    // Lowers valid, waits for every outstanding reading, then lets the pipeline empty.
    task automatic settle();
        @(negedge clk);
        events.valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Duration pickers; they assume the timeout is at least two above the threshold.
    function automatic logic [DUR_W-1:0] low_len();
        return DUR_W'($urandom_range(0, tmo_us - 1));
    endfunction

    function automatic logic [DUR_W-1:0] pulse_len(input bit one);
        return one ? DUR_W'($urandom_range(thr_us + 1, tmo_us - 1))
                   : DUR_W'($urandom_range(0, thr_us));
    endfunction

    function automatic logic [DUR_W-1:0] closing_len();
        return DUR_W'($urandom_range(tmo_us, 1023));
    endfunction

    function automatic logic [FRAME_BITS-1:0] make_word(input logic [15:0] hum,
                                                       input logic [15:0] temp_raw,
                                                       input bit good_sum);
        logic [7:0] sum8;
        sum8 = hum[15:8] + hum[7:0] + temp_raw[15:8] + temp_raw[7:0];
        if (!good_sum)
            sum8 = sum8 + 8'($urandom_range(1, 255));
        return {hum, temp_raw, sum8};
    endfunction

    function automatic logic [FRAME_BITS-1:0] random_word();
        logic [15:0] hum;
        hum = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1001, 65535))
                                          : 16'($urandom_range(0, 1000));
        return make_word(hum, 16'($urandom), $urandom_range(0, 9) != 0);
    endfunction

    // One start beat and then the given number of level changes. With cut_short the
    // last change is long enough to close the frame on timeout.
    task automatic send_frame(input logic [FRAME_BITS-1:0] word, input int changes,
                              input bit cut_short);
        logic [DUR_W-1:0] dur;
        int               k;
        send_event(FUNC_START, DUR_W'($urandom));
        for (int i = 0; i < changes; i++)
        begin
            if (i > 2 && i % 2 == 0)
            begin
                k   = (i - FIRST_BIT_CHG) / 2;
                dur = pulse_len(k < FRAME_BITS ? word[FRAME_BITS-1-k] : 1'($urandom));
            end
            else
                dur = low_len();
            if (cut_short && i == changes - 1)
                dur = closing_len();
            send_event(FUNC_CHANGE, dur);
        end
    endtask

    task automatic test_short_frames();
        send_event(FUNC_CHANGE, '0);
        send_event(FUNC_CHANGE, 10'd1023);
        send_event(FUNC_START, 10'd1023);
        send_event(FUNC_CHANGE, '0);
        send_event(FUNC_CHANGE, 10'd249);
        send_event(FUNC_CHANGE, 10'd250);
        // A start in the middle of a frame drops it without a reading.
        send_event(FUNC_START, '0);
        send_event(FUNC_CHANGE, 10'd30);
        send_event(FUNC_START, 10'd500);
        send_event(FUNC_CHANGE, 10'd1023);
        send_event(FUNC_CHANGE, 10'd5);
        settle();
    endtask

    task automatic test_register_limits();
        write_reg(REG_TIMEOUT, '0);
        send_event(FUNC_START, '0);
        send_event(FUNC_CHANGE, '0);
        settle();
        write_reg(REG_TIMEOUT, 10'd1);
        send_event(FUNC_START, '0);
        send_event(FUNC_CHANGE, '0);
        send_event(FUNC_CHANGE, '0);
        send_event(FUNC_CHANGE, 10'd1);
        settle();
        write_reg(REG_UNUSED, 10'h3FF);
        send_event(FUNC_START, '0);
        send_event(FUNC_CHANGE, 10'd1023);
        settle();
        // Data wider than the register is cut to its width.
        write_reg(REG_BIT_THRESHOLD, 10'h3FF);
        write_reg(REG_TIMEOUT, 10'h3FF);
        write_reg(REG_FAHRENHEIT, 10'h3FE);
        send_event(FUNC_START, '0);
        send_event(FUNC_CHANGE, 10'd1022);
        send_event(FUNC_CHANGE, 10'd1023);
        settle();
    endtask

    task automatic test_reading_extremes();
        set_regs(255, 1023, 1'b0);
        send_frame(make_word(16'd1000, 16'h7FFF, 1'b1), MAX_CHANGES, 1'b0);
        settle();
        write_reg(REG_FAHRENHEIT, 10'd1);
        send_frame(make_word(16'd0, 16'hFFFF, 1'b1), MAX_CHANGES, 1'b0);
        settle();
        set_regs(0, 2, 1'b1);
        // Forty bits and a close on timeout just after the last one; humidity one
        // above the limit.
        send_frame(make_word(16'd1001, 16'h8000, 1'b1), MAX_CHANGES - 1, 1'b1);
        settle();
    endtask

    task automatic test_output_stall();
        set_regs(48, 250, 1'b1);
        stall_request = 150;
        repeat (24)
        begin
            send_event(FUNC_START, '0);
            send_event(FUNC_CHANGE, closing_len());
        end
        settle();
    endtask

    task automatic run_random_phase(input int want_readings, input int want_beats);
        int readings_at;
        int beats_at;
        int pick;
        readings_at = readings_due;
        beats_at    = live_beats;
        while (readings_due - readings_at < want_readings || live_beats - beats_at < want_beats)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_frame(random_word(), MAX_CHANGES, 1'b0);
            else if (pick < 60)
                send_frame(random_word(), MAX_CHANGES - 1, 1'b1);
            else if (pick < 75)
                send_frame(random_word(), $urandom_range(1, MAX_CHANGES), 1'b1);
            else if (pick < 85)
                send_frame(random_word(), $urandom_range(0, MAX_CHANGES - 1), 1'b0);
            else
                repeat ($urandom_range(1, 8)) send_event(1'($urandom), DUR_W'($urandom));
        end
        settle();
    endtask

    task automatic test_random_frames();
        int thr;
        calm = 1'b1;
        set_regs(48, 250, 1'b0);
        run_random_phase(1, 20);
        calm = 1'b0;
        thr = $urandom_range(0, 200);
        set_regs(thr, $urandom_range(thr + 2, 1023), 1'($urandom));
        run_random_phase(1, 20);
    endtask

    // Reading sink: random stalls, plus a long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left     = 0;
        reading.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request > 0)
            begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                reading.ready <= 1'b0;
            end
            else
                reading.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin : check_reading
        reading_t want;
        if (rst_n && reading.valid && reading.ready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("unexpected reading beat, humidity",
                                reading.humidity_tenths, 0);
            else
            begin
                want = expected_readings.pop_front();
                if (reading.valid_res !== want.valid_res)
                    report_mismatch("valid_res", reading.valid_res, want.valid_res);
                if (reading.humidity_tenths !== want.humidity_tenths)
                    report_mismatch("humidity_tenths", reading.humidity_tenths,
                                    want.humidity_tenths);
                if (reading.temperature_tenths !== want.temperature_tenths)
                    report_mismatch("temperature_tenths",
                                    $signed(reading.temperature_tenths),
                                    $signed(want.temperature_tenths));
            end
        end
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        events.valid       = 1'b0;
        events.func        = FUNC_START;
        events.duration_us = '0;
        reset_decoder_copy();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_short_frames();
        test_register_limits();
        test_reading_extremes();
        test_output_stall();
        test_random_frames();

        settle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
